[rtl/byte_ring_with_history_copy_assert.svh]
// ----------------------------------------------------------------------------
// Byte ring assertion macros
// Shared assertion forms for the byte ring; they compile away under SYNTH.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_WITH_HISTORY_COPY_ASSERT_SVH
`define BYTE_RING_WITH_HISTORY_COPY_ASSERT_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define BRHC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brhc: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define BRHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brhc: next-cycle check failed");
`else
`define BRHC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define BRHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/brhc_pkg.sv]
// ----------------------------------------------------------------------------
// Byte ring package
// Field widths, operation and status codes, and the shared types.
// ----------------------------------------------------------------------------
package brhc_pkg;

    // Default ring capacity in bytes.
    localparam int DEPTH_DEF = 4096;

    // Fixed field widths of the item channels.
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 3;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 2;

    // Operation codes carried in the kind field.
    localparam logic [KIND_W-1:0] K_WRITE   = 3'd0;
    localparam logic [KIND_W-1:0] K_READ    = 3'd1;
    localparam logic [KIND_W-1:0] K_COPY    = 3'd2;
    localparam logic [KIND_W-1:0] K_DISCARD = 3'd3;
    localparam logic [KIND_W-1:0] K_PEEK    = 3'd4;
    localparam logic [KIND_W-1:0] K_CLEAR   = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef logic [COUNT_W-1:0] t_count;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PEEK_RD,
        S_RD_WAIT,
        S_COPY_RD,
        S_COPY_WR,
        S_DONE
    } t_state;

    // One captured input item.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  data_in;
        logic [COUNT_W-1:0] back_distance;
        logic [COUNT_W-1:0] amount;
    } t_item;

    // One finished result item.
    typedef struct packed {
        logic [BYTE_W-1:0]   data_out;
        logic [COUNT_W-1:0]  done_count;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  fill_level;
        logic [COUNT_W-1:0]  history_span;
    } t_result;

endpackage

[rtl/brhc_if.sv]
// ----------------------------------------------------------------------------
// Byte ring channel interfaces
// Valid/ready channels for operation items and for result items.
// ----------------------------------------------------------------------------

// Operation item channel.
interface brhc_in_if;
    logic                            valid;
    logic                            ready;
    logic [brhc_pkg::KIND_W-1:0]     kind;
    logic [brhc_pkg::BYTE_W-1:0]     data_in;
    logic [brhc_pkg::COUNT_W-1:0]    back_distance;
    logic [brhc_pkg::COUNT_W-1:0]    amount;

    modport source (output valid, output kind, output data_in, output back_distance,
                    output amount, input ready);
    modport sink   (input valid, input kind, input data_in, input back_distance,
                    input amount, output ready);
endinterface

// Result item channel.
interface brhc_out_if;
    logic                            valid;
    logic                            ready;
    logic [brhc_pkg::BYTE_W-1:0]     data_out;
    logic [brhc_pkg::COUNT_W-1:0]    done_count;
    logic [brhc_pkg::STATUS_W-1:0]   status;
    logic [brhc_pkg::COUNT_W-1:0]    fill_level;
    logic [brhc_pkg::COUNT_W-1:0]    history_span;

    modport source (output valid, output data_out, output done_count, output status,
                    output fill_level, output history_span, input ready);
    modport sink   (input valid, input data_out, input done_count, input status,
                    input fill_level, input history_span, output ready);
endinterface

[rtl/brhc_ram.sv]
// ----------------------------------------------------------------------------
// Byte ring generic RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module brhc_ram #(
    parameter int WIDTH = brhc_pkg::BYTE_W,
    parameter int DEPTH = brhc_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with the data registered.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/brhc_modadd.sv]
// ----------------------------------------------------------------------------
// Byte ring pointer adder
// Shared modular add and subtract of a ring offset to a ring address.
// ----------------------------------------------------------------------------
module brhc_modadd #(
    parameter int DEPTH = brhc_pkg::DEPTH_DEF
) (
    input  logic [$clog2(DEPTH)-1:0]   i_a,
    input  logic [$clog2(DEPTH+1)-1:0] i_b,
    input  logic                       i_sub,
    output logic [$clog2(DEPTH)-1:0]   o_sum
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [SW-1:0] w_raw;
    logic [SW-1:0] w_wrap;

    // The offset never exceeds the depth, so one conditional subtract folds the
    // raw sum back into the ring. A subtract is done as an add of depth minus b.
    always_comb begin
        if (i_sub) begin
            w_raw = SW'(i_a) + SW'(DEPTH) - SW'(i_b);
        end else begin
            w_raw = SW'(i_a) + SW'(i_b);
        end
        if (w_raw >= SW'(DEPTH)) begin
            w_wrap = w_raw - SW'(DEPTH);
        end else begin
            w_wrap = w_raw;
        end
    end

    assign o_sum = AW'(w_wrap);

endmodule

[rtl/brhc_seq.sv]
// ----------------------------------------------------------------------------
// Byte ring sequencer
// Runs each operation item in steps over the ring RAM and the pointer adder.
// ----------------------------------------------------------------------------
module brhc_seq #(
    parameter int DEPTH = brhc_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    brhc_in_if.sink             i_in,
    input  logic                i_slot_free,
    output logic                o_res_valid,
    output brhc_pkg::t_result   o_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > brhc_pkg::COUNT_W) ? CW : brhc_pkg::COUNT_W;

    brhc_pkg::t_state r_state, n_state;
    brhc_pkg::t_item  r_item, n_item;

    logic [AW-1:0]                 r_rp, n_rp;
    logic [AW-1:0]                 r_wp, n_wp;
    logic [AW-1:0]                 r_src, n_src;
    logic [CW-1:0]                 r_fill, n_fill;
    logic [CW-1:0]                 r_hist, n_hist;
    logic [CW-1:0]                 r_done, n_done;
    logic [brhc_pkg::STATUS_W-1:0] r_status, n_status;
    logic [brhc_pkg::BYTE_W-1:0]   r_data, n_data;

    logic                          ram_we;
    logic                          ram_re;
    logic [AW-1:0]                 ram_waddr;
    logic [AW-1:0]                 ram_raddr;
    logic [brhc_pkg::BYTE_W-1:0]   ram_wdata;
    logic [brhc_pkg::BYTE_W-1:0]   ram_rdata;

    logic [AW-1:0]                 u_a;
    logic [CW-1:0]                 u_b;
    logic                          u_sub;
    logic [AW-1:0]                 u_sum;

    logic w_full;
    logic w_hist_full;
    logic w_empty;
    logic w_dist_over;
    logic w_dist_zero;
    logic w_amt_over;
    logic w_amt_zero;
    logic w_copy_go;
    logic w_peek_go;
    logic w_copy_last;

    // Ring storage.
    brhc_ram #(
        .WIDTH (brhc_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The one pointer adder, shared by every step.
    brhc_modadd #(
        .DEPTH (DEPTH)
    ) u_modadd (
        .i_a   (u_a),
        .i_b   (u_b),
        .i_sub (u_sub),
        .o_sum (u_sum)
    );

    // Range checks on the captured item against the current counts.
    assign w_full      = (r_fill == CW'(DEPTH));
    assign w_hist_full = (r_hist == CW'(DEPTH));
    assign w_empty     = (r_fill == '0);
    assign w_dist_over = (XW'(r_item.back_distance) > XW'(r_hist));
    assign w_dist_zero = (r_item.back_distance == '0);
    assign w_amt_over  = (XW'(r_item.amount) > XW'(r_fill));
    assign w_amt_zero  = (r_item.amount == '0);
    assign w_copy_go   = !w_dist_over && !w_dist_zero && !w_amt_zero && !w_full;
    assign w_peek_go   = !w_dist_over && !w_dist_zero;

    // The copy ends on its last requested byte or when the ring fills up.
    assign w_copy_last = ((XW'(r_done) + XW'(1)) == XW'(r_item.amount))
                      || ((r_fill + CW'(1)) == CW'(DEPTH));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            brhc_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_state = brhc_pkg::S_EXEC;
                end
            end
            brhc_pkg::S_EXEC: begin
                n_state = brhc_pkg::S_DONE;
                case (r_item.kind)
                    brhc_pkg::K_READ: begin
                        if (!w_empty) begin
                            n_state = brhc_pkg::S_RD_WAIT;
                        end
                    end
                    brhc_pkg::K_COPY: begin
                        if (w_copy_go) begin
                            n_state = brhc_pkg::S_COPY_RD;
                        end
                    end
                    brhc_pkg::K_PEEK: begin
                        if (w_peek_go) begin
                            n_state = brhc_pkg::S_PEEK_RD;
                        end
                    end
                    default: begin
                        n_state = brhc_pkg::S_DONE;
                    end
                endcase
            end
            brhc_pkg::S_PEEK_RD: begin
                n_state = brhc_pkg::S_RD_WAIT;
            end
            brhc_pkg::S_RD_WAIT: begin
                n_state = brhc_pkg::S_DONE;
            end
            brhc_pkg::S_COPY_RD: begin
                n_state = brhc_pkg::S_COPY_WR;
            end
            brhc_pkg::S_COPY_WR: begin
                if (w_copy_last) begin
                    n_state = brhc_pkg::S_DONE;
                end else begin
                    n_state = brhc_pkg::S_COPY_RD;
                end
            end
            brhc_pkg::S_DONE: begin
                if (i_slot_free) begin
                    n_state = brhc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = brhc_pkg::S_IDLE;
            end
        endcase
    end

    // Step outputs: RAM port controls, adder operands and register updates.
    always_comb begin
        n_item    = r_item;
        n_rp      = r_rp;
        n_wp      = r_wp;
        n_src     = r_src;
        n_fill    = r_fill;
        n_hist    = r_hist;
        n_done    = r_done;
        n_status  = r_status;
        n_data    = r_data;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_wp;
        ram_raddr = r_rp;
        ram_wdata = r_item.data_in;
        u_a       = r_wp;
        u_b       = CW'(1);
        u_sub     = 1'b0;
        case (r_state)
            brhc_pkg::S_IDLE: begin
                // Capture the item and clear the per-item result fields.
                if (i_in.valid) begin
                    n_item.kind          = i_in.kind;
                    n_item.data_in       = i_in.data_in;
                    n_item.back_distance = i_in.back_distance;
                    n_item.amount        = i_in.amount;
                end
                n_done   = '0;
                n_status = brhc_pkg::ST_OK;
                n_data   = '0;
            end
            brhc_pkg::S_EXEC: begin
                case (r_item.kind)
                    brhc_pkg::K_WRITE: begin
                        if (w_full) begin
                            n_status = brhc_pkg::ST_NONE;
                        end else begin
                            ram_we = 1'b1;
                            n_wp   = u_sum;
                            n_fill = r_fill + CW'(1);
                            if (!w_hist_full) begin
                                n_hist = r_hist + CW'(1);
                            end
                            n_done = CW'(1);
                        end
                    end
                    brhc_pkg::K_READ: begin
                        if (w_empty) begin
                            n_status = brhc_pkg::ST_NONE;
                        end else begin
                            ram_re = 1'b1;
                            u_a    = r_rp;
                            n_rp   = u_sum;
                            n_fill = r_fill - CW'(1);
                            n_done = CW'(1);
                        end
                    end
                    brhc_pkg::K_COPY: begin
                        if (w_dist_over) begin
                            n_status = brhc_pkg::ST_RANGE;
                        end else if (w_dist_zero || w_amt_zero) begin
                            n_status = brhc_pkg::ST_OK;
                        end else if (w_full) begin
                            n_status = brhc_pkg::ST_NONE;
                        end else begin
                            // Source address of the first copied byte.
                            u_b   = CW'(r_item.back_distance);
                            u_sub = 1'b1;
                            n_src = u_sum;
                        end
                    end
                    brhc_pkg::K_DISCARD: begin
                        if (w_amt_over) begin
                            n_status = brhc_pkg::ST_RANGE;
                        end else begin
                            u_a    = r_rp;
                            u_b    = CW'(r_item.amount);
                            n_rp   = u_sum;
                            n_fill = r_fill - CW'(r_item.amount);
                            n_done = CW'(r_item.amount);
                        end
                    end
                    brhc_pkg::K_PEEK: begin
                        if (w_dist_over) begin
                            n_status = brhc_pkg::ST_RANGE;
                        end else if (!w_dist_zero) begin
                            u_b    = CW'(r_item.back_distance);
                            u_sub  = 1'b1;
                            n_src  = u_sum;
                            n_done = CW'(1);
                        end
                    end
                    brhc_pkg::K_CLEAR: begin
                        n_rp   = '0;
                        n_wp   = '0;
                        n_fill = '0;
                        n_hist = '0;
                    end
                    default: begin
                        n_status = brhc_pkg::ST_OK;
                    end
                endcase
            end
            brhc_pkg::S_PEEK_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_src;
            end
            brhc_pkg::S_RD_WAIT: begin
                n_data = ram_rdata;
            end
            brhc_pkg::S_COPY_RD: begin
                // Fetch the source byte and step the source address.
                ram_re    = 1'b1;
                ram_raddr = r_src;
                u_a       = r_src;
                n_src     = u_sum;
            end
            brhc_pkg::S_COPY_WR: begin
                // Append the fetched byte at the write point.
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_wp      = u_sum;
                n_fill    = r_fill + CW'(1);
                if (!w_hist_full) begin
                    n_hist = r_hist + CW'(1);
                end
                n_done    = r_done + CW'(1);
            end
            brhc_pkg::S_DONE: begin
                n_status = r_status;
            end
            default: begin
                n_status = r_status;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brhc_pkg::S_IDLE;
            r_rp    <= '0;
            r_wp    <= '0;
            r_fill  <= '0;
            r_hist  <= '0;
        end else begin
            r_state <= n_state;
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_fill  <= n_fill;
            r_hist  <= n_hist;
        end
    end

    // Item and result payload registers.
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_src    <= n_src;
        r_done   <= n_done;
        r_status <= n_status;
        r_data   <= n_data;
    end

    // Handshake and result.
    assign i_in.ready          = (r_state == brhc_pkg::S_IDLE);
    assign o_res_valid         = (r_state == brhc_pkg::S_DONE);
    assign o_res.data_out      = r_data;
    assign o_res.done_count    = brhc_pkg::t_count'(r_done);
    assign o_res.status        = r_status;
    assign o_res.fill_level    = brhc_pkg::t_count'(r_fill);
    assign o_res.history_span  = brhc_pkg::t_count'(r_hist);

endmodule

[rtl/byte_ring_with_history_copy.sv]
// ----------------------------------------------------------------------------
// Byte ring with history copy: one operation item at a time; the result is
// registered after the sequencer steps (read and peek through the registered
// RAM read, a copy through a read and a write step per byte). A new item is
// taken only after the sequencer hands its result to a free output register.
// Synchronous reset clears pointers and counts; ring bytes stay undefined.
// ----------------------------------------------------------------------------
`include "byte_ring_with_history_copy_assert.svh"

module byte_ring_with_history_copy #(
    parameter int DEPTH = brhc_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    brhc_in_if.sink     i_in,
    brhc_out_if.source  o_out
);

    logic               w_res_valid;
    brhc_pkg::t_result  w_res;
    logic               w_slot_free;
    logic               r_out_valid;
    brhc_pkg::t_result  r_out;
    logic               w_out_fail;

    // Operation sequencer with the ring RAM and pointer adder.
    brhc_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_slot_free (w_slot_free),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // The output register is free when empty or being taken this cycle.
    assign w_slot_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_slot_free) begin
            r_out <= w_res;
        end
    end

    // Result channel.
    assign o_out.valid        = r_out_valid;
    assign o_out.data_out     = r_out.data_out;
    assign o_out.done_count   = r_out.done_count;
    assign o_out.status       = r_out.status;
    assign o_out.fill_level   = r_out.fill_level;
    assign o_out.history_span = r_out.history_span;

    // A held result that reports a refused or out-of-range operation.
    assign w_out_fail = r_out_valid && (r_out.status != brhc_pkg::ST_OK);

    // An item is never accepted while the sequencer offers a result.
    `BRHC_ASSERT_SAME(a_accept_not_done, i_clk, i_rst_n, i_in.valid && i_in.ready, !w_res_valid)
    // The sequencer is busy right after it takes an item.
    `BRHC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    // A result offered to a free output register shows up there next cycle.
    `BRHC_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, w_res_valid && w_slot_free, r_out_valid)
    // A refused or out-of-range operation reports no bytes done.
    `BRHC_ASSERT_SAME(a_fail_no_count, i_clk, i_rst_n, w_out_fail, r_out.done_count == '0)

endmodule
